// ===== hdl/assert_macros.svh =====
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/iba_pkg.sv =====
// Package with the allocator's defaults, opcodes and status codes.
`timescale 1ns / 1ps
package iba_pkg;
   localparam int NUM_BLOCKS_DEFAULT      = 128;
   localparam int NUM_INODES_DEFAULT      = 16;
   localparam int MAX_FILE_BLOCKS_DEFAULT = 8;
   localparam int BLOCK_BYTES_DEFAULT     = 1024;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ARG   = 3'd1;
   localparam logic [2:0] ST_NO_SPACE  = 3'd2;
   localparam logic [2:0] ST_NO_INODE  = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_RANGE     = 3'd5;
endpackage

// ===== hdl/iba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module iba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/inode_block_allocator_core.sv =====
// Top level of the inode and block allocator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One command is taken when start is high and busy is low; exactly one
// response follows as a one-cycle rsp_valid strobe that the receiver cannot
// stall. After reset the block map RAM is cleared one block per cycle, and busy
// stays high until the clear is done and the first command can be taken. A delete
// does one pointer RAM read and one map clear per block; a create scans the block
// map one block per cycle from block 1 until enough free blocks are found or the
// last block is scanned, then writes one pointer per cycle. Block pointers and the
// block map live in RAMs; inode names, sizes and used bits are flops.
module inode_block_allocator_core #(
   parameter int NUM_BLOCKS      = iba_pkg::NUM_BLOCKS_DEFAULT,
   parameter int NUM_INODES      = iba_pkg::NUM_INODES_DEFAULT,
   parameter int MAX_FILE_BLOCKS = iba_pkg::MAX_FILE_BLOCKS_DEFAULT,
   parameter int BLOCK_BYTES     = iba_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_file_name,
   input  logic [3:0]  req_size_blocks,
   input  logic [2:0]  req_block_index,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_inode_index,
   output logic [6:0]  rsp_block_address,
   output logic [16:0] rsp_byte_offset
);
   localparam int BW = $clog2(NUM_BLOCKS);
   localparam int SW = (NUM_INODES > 1) ? $clog2(NUM_INODES) : 1;
   localparam int IW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int PDEPTH = NUM_INODES * MAX_FILE_BLOCKS;
   localparam int AW = $clog2(PDEPTH);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_ALLOC   = 4'd3;
   localparam logic [3:0] S_COMMIT  = 4'd4;
   localparam logic [3:0] S_DEL_RD  = 4'd5;
   localparam logic [3:0] S_DEL_WR  = 4'd6;
   localparam logic [3:0] S_LK_WAIT = 4'd7;
   localparam logic [3:0] S_CLEAR   = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic [63:0] name_ff;
   logic [3:0]  size_ff;
   logic [2:0]  bidx_ff;
   logic [NUM_INODES-1:0] used_ff, used_in;
   logic [63:0] iname_ff [NUM_INODES];
   logic [3:0]  isize_ff [NUM_INODES];
   logic [BW-1:0] picks_ff [MAX_FILE_BLOCKS];
   logic [BW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] got_ff, got_in;
   logic [CW-1:0] k_ff, k_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   logic [3:0]    inode_ff, inode_in;
   logic [6:0]    addr_ff, addr_in;
   logic [16:0]   offs_ff, offs_in;

   logic [63:0]   canon;
   logic          stop;
   logic          match_found, free_found;
   logic [SW-1:0] match_idx, free_idx;
   logic          pick_en, inode_wr;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [BW-1:0] ram_wdata, ram_rdata;
   logic          map_we, map_wdata, map_rdata;
   logic [BW-1:0] map_waddr, map_raddr;
   logic [31:0]   ptr32;

   // Bytes after the first zero byte are dropped before the name is stored.
   always_comb begin
      canon = '0;
      stop  = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (req_file_name[8*b +: 8] == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            canon[8*b +: 8] = req_file_name[8*b +: 8];
         end
      end
   end

   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      free_found  = 1'b0;
      free_idx    = '0;
      for (int i = NUM_INODES - 1; i >= 0; i--) begin
         if (used_ff[i] && iname_ff[i] == name_ff) begin
            match_found = 1'b1;
            match_idx   = SW'(i);
         end
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   assign ptr32 = 32'(ram_rdata);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      cursor_in    = cursor_ff;
      got_in       = got_ff;
      k_in         = k_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      inode_in     = inode_ff;
      addr_in      = addr_ff;
      offs_in      = offs_ff;
      pick_en      = 1'b0;
      inode_wr     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = AW'(slot_ff) * AW'(MAX_FILE_BLOCKS) + AW'(k_ff);
      ram_wdata    = picks_ff[k_ff[IW-1:0]];
      ram_raddr    = AW'(slot_ff) * AW'(MAX_FILE_BLOCKS) + AW'(k_ff);
      map_we       = 1'b0;
      map_waddr    = cursor_ff;
      map_wdata    = 1'b0;
      map_raddr    = cursor_ff + BW'(1);
      case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            cursor_in = cursor_ff + BW'(1);
            if (32'(cursor_ff) == NUM_BLOCKS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = iba_pkg::ST_OK;
            inode_in  = '0;
            addr_in   = '0;
            offs_in   = '0;
            ram_raddr = AW'(match_idx) * AW'(MAX_FILE_BLOCKS) + AW'(bidx_ff);
            slot_in   = match_idx;
            k_in      = '0;
            case (op_ff)
               iba_pkg::OP_CREATE: begin
                  if (size_ff == 4'd0 || 32'(size_ff) > MAX_FILE_BLOCKS ||
                      name_ff == 64'd0) begin
                     status_in    = iba_pkg::ST_BAD_ARG;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     // The map read for block 1 goes out now and returns in the
                     // first scan cycle.
                     map_raddr = BW'(1);
                     cursor_in = BW'(1);
                     got_in    = '0;
                     state_in  = S_SCAN;
                  end
               end
               iba_pkg::OP_DELETE: begin
                  if (!match_found) begin
                     status_in    = iba_pkg::ST_NOT_FOUND;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_DEL_RD;
                  end
               end
               iba_pkg::OP_LOOKUP: begin
                  if (!match_found) begin
                     status_in    = iba_pkg::ST_NOT_FOUND;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else if (4'(bidx_ff) >= isize_ff[match_idx] ||
                               32'(bidx_ff) >= MAX_FILE_BLOCKS) begin
                     status_in    = iba_pkg::ST_RANGE;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_LK_WAIT;
                  end
               end
               default: begin
                  status_in    = iba_pkg::ST_BAD_ARG;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // The map data here belongs to cursor_ff; the next block is read.
            if (!map_rdata) begin
               pick_en = 1'b1;
               got_in  = got_ff + CW'(1);
            end
            cursor_in = cursor_ff + BW'(1);
            if (32'(got_in) == 32'(size_ff) || 32'(cursor_ff) == NUM_BLOCKS - 1) begin
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (32'(got_ff) < 32'(size_ff)) begin
               status_in    = iba_pkg::ST_NO_SPACE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (!free_found) begin
               status_in    = iba_pkg::ST_NO_INODE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               inode_wr          = 1'b1;
               used_in[free_idx] = 1'b1;
               slot_in           = free_idx;
               k_in              = '0;
               state_in          = S_COMMIT;
            end
         end
         S_COMMIT: begin
            ram_we    = 1'b1;
            map_we    = 1'b1;
            map_waddr = picks_ff[k_ff[IW-1:0]];
            map_wdata = 1'b1;
            k_in      = k_ff + CW'(1);
            if (32'(k_ff) + 1 == 32'(size_ff)) begin
               inode_in     = 4'(32'(slot_ff));
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DEL_RD: begin
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            map_we    = 1'b1;
            map_waddr = ram_rdata;
            map_wdata = 1'b0;
            k_in      = k_ff + CW'(1);
            if (32'(k_ff) + 1 >= 32'(isize_ff[slot_ff])) begin
               used_in[slot_ff] = 1'b0;
               inode_in         = 4'(32'(slot_ff));
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_LK_WAIT: begin
            inode_in     = 4'(32'(slot_ff));
            addr_in      = ptr32[6:0];
            offs_in      = 17'(ptr32 * 32'(BLOCK_BYTES));
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cursor_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff   <= req_opcode;
         name_ff <= canon;
         size_ff <= req_size_blocks;
         bidx_ff <= req_block_index;
      end
      if (pick_en) begin
         picks_ff[got_ff[IW-1:0]] <= cursor_ff;
      end
      if (inode_wr) begin
         iname_ff[free_idx] <= name_ff;
         isize_ff[free_idx] <= size_ff;
      end
      got_ff    <= got_in;
      k_ff      <= k_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      inode_ff  <= inode_in;
      addr_ff   <= addr_in;
      offs_ff   <= offs_in;
   end

   iba_ram #(
      .WIDTH(BW),
      .DEPTH(PDEPTH)
   ) u_ptr_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   iba_ram #(
      .WIDTH(1),
      .DEPTH(NUM_BLOCKS)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (map_we),
      .wr_addr(map_waddr),
      .wr_data(map_wdata),
      .rd_addr(map_raddr),
      .rd_data(map_rdata)
   );

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_inode_index   = inode_ff;
   assign rsp_block_address = addr_ff;
   assign rsp_byte_offset   = offs_ff;

   // A response always returns the block to idle and lasts a single cycle.
   `ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   // Block 0 is reserved and is never marked as taken.
   `ASSERT_IMPLY(a_block0_free, clock, reset, map_we && map_wdata, map_waddr != '0)
   // The scan never collects more blocks than were requested.
   `ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == S_SCAN,
      32'(got_ff) < 32'(size_ff))
endmodule
